// ----- rtl/core/rational_add_sub_reduce_macros.svh -----
// Assertion macros for the checks in rational_add_sub_reduce.
`ifndef RATIONAL_ADD_SUB_REDUCE_MACROS_SVH
`define RATIONAL_ADD_SUB_REDUCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RASR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_add_sub_reduce: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RASR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_add_sub_reduce: next-cycle check failed");

`endif

// ----- rtl/core/rasr_pkg.sv -----
`timescale 1ns / 1ps

package rasr_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 16;
    localparam int MAX_WORK_WIDTH        = 64;
    localparam int RESULT_NUM_WIDTH      = 33;
    localparam int RESULT_DEN_WIDTH      = 32;

    localparam logic OPC_ADD = 1'b0;
    localparam logic OPC_SUB = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/rational_add_sub_reduce.sv -----
`timescale 1ns / 1ps
// Adds or subtracts two signed fractions and returns the result reduced by a gcd.
// Input channel: in_valid/in_ready carry first_num, first_den, second_num,
// second_den and opcode (0 adds, 1 subtracts the second fraction from the first).
// Output channel: out_valid/out_ready carry result_num, result_den and error.
// A zero denominator on either input gives error with a zero result, written from
// the S_OUT state once the output register is free.
// Otherwise each operand and then the sum are reduced by Euclid's algorithm on one
// shared restoring divider, one quotient bit per cycle, with a working width
// W = 2*OPERAND_WIDTH+1 (at most 64), which is 33 bits at the default.
// The time to the result depends on the data; when the result is written the
// sequencer returns to S_IDLE and can take the next transaction, so one item is
// worked on at a time.
// The finished result sits in an output register, so a new transaction is taken
// while the previous result still waits for out_ready; a stalled receiver only
// holds the block once the next result is ready to be written.
// Reset clears the sequencer and drops out_valid.
`include "rational_add_sub_reduce_macros.svh"

module rational_add_sub_reduce #(
    parameter int OPERAND_WIDTH = rasr_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [OPERAND_WIDTH-1:0]          first_num,
    input  logic signed [OPERAND_WIDTH-1:0]          first_den,
    input  logic signed [OPERAND_WIDTH-1:0]          second_num,
    input  logic signed [OPERAND_WIDTH-1:0]          second_den,
    input  logic                                     opcode,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [rasr_pkg::RESULT_NUM_WIDTH-1:0] result_num,
    output logic signed [rasr_pkg::RESULT_DEN_WIDTH-1:0] result_den,
    output logic                                     error
);

    localparam int OW = OPERAND_WIDTH;
    localparam int WW = (2 * OW + 1 > rasr_pkg::MAX_WORK_WIDTH) ?
                        rasr_pkg::MAX_WORK_WIDTH : 2 * OW + 1;
    localparam int EXT_W = rasr_pkg::MAX_WORK_WIDTH + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_GCD_WAIT, S_DIVN, S_DIVN_WAIT, S_DIVD, S_DIVD_WAIT,
        S_MUL_A, S_MUL_B, S_MUL_C, S_OUT
    } state_t;

    typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_RESULT} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic signed [WW-1:0] n1_reg, n1_next, d1_reg, d1_next;
    logic signed [WW-1:0] n2_reg, n2_next, d2_reg, d2_next;
    logic signed [WW-1:0] a_reg, a_next, b_reg, b_next;
    logic signed [WW-1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic                 sub_reg, sub_next;
    logic                 err_reg, err_next;
    logic                 oerr_reg, oerr_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [rasr_pkg::RESULT_NUM_WIDTH-1:0] rnum_reg, rnum_next;
    logic signed [rasr_pkg::RESULT_DEN_WIDTH-1:0] rden_reg, rden_next;

    logic signed [WW-1:0]   x_sel, y_sel;
    logic signed [WW-1:0]   div_x, div_y, div_q, div_r;
    logic                   div_start;
    rasr_pkg::div_stat_t    div_stat;
    logic signed [OW:0]     mul_a, mul_b;
    logic signed [2*OW+1:0] prod;
    logic signed [WW-1:0]   prod_w, sum_w;
    logic [EXT_W-1:0]       n_ext, d_ext;
    logic                   advance;

    rasr_div #(
        .WORK_WIDTH(WW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_x),
        .divisor   (div_y),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    // After reduction a value may need one bit beyond the operand width (minimum over -1).
    assign prod   = mul_a * mul_b;
    assign prod_w = prod[WW-1:0];
    assign sum_w  = (sub_reg == rasr_pkg::OPC_SUB) ? ta_reg - tb_reg : ta_reg + tb_reg;
    assign x_sel  = (phase_reg == PH_SECOND) ? n2_reg : n1_reg;
    assign y_sel  = (phase_reg == PH_SECOND) ? d2_reg : d1_reg;
    assign n_ext  = {{(EXT_W-WW){n1_reg[WW-1]}}, n1_reg};
    assign d_ext  = {{(EXT_W-WW){d1_reg[WW-1]}}, d1_reg};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        n1_next        = n1_reg;
        d1_next        = d1_reg;
        n2_next        = n2_reg;
        d2_next        = d2_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        sub_next       = sub_reg;
        err_next       = err_reg;
        oerr_next      = oerr_reg;
        rnum_next      = rnum_reg;
        rden_next      = rden_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        div_x          = x_sel;
        div_y          = a_reg;
        mul_a          = n1_reg[OW:0];
        mul_b          = d2_reg[OW:0];
        advance        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n1_next  = {{(WW-OW){first_num[OW-1]}}, first_num};
                    d1_next  = {{(WW-OW){first_den[OW-1]}}, first_den};
                    n2_next  = {{(WW-OW){second_num[OW-1]}}, second_num};
                    d2_next  = {{(WW-OW){second_den[OW-1]}}, second_den};
                    a_next   = {{(WW-OW){first_num[OW-1]}}, first_num};
                    b_next   = {{(WW-OW){first_den[OW-1]}}, first_den};
                    sub_next = opcode;
                    phase_next = PH_FIRST;
                    if (first_den == '0 || second_den == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (b_reg == '0)
                begin
                    state_next = S_DIVN;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_x      = a_reg;
                    div_y      = b_reg;
                    state_next = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (div_stat.done)
                begin
                    a_next     = b_reg;
                    b_next     = div_r;
                    state_next = S_GCD;
                end
            end
            S_DIVN:
            begin
                if (a_reg == '0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVN_WAIT;
                end
            end
            S_DIVN_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (phase_reg == PH_SECOND)
                    begin
                        n2_next = div_q;
                    end
                    else
                    begin
                        n1_next = div_q;
                    end
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                div_start  = 1'b1;
                div_x      = y_sel;
                state_next = S_DIVD_WAIT;
            end
            S_DIVD_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (phase_reg == PH_SECOND)
                    begin
                        d2_next = div_q;
                    end
                    else
                    begin
                        d1_next = div_q;
                    end
                    advance = 1'b1;
                end
            end
            S_MUL_A:
            begin
                ta_next    = prod_w;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                mul_a      = n2_reg[OW:0];
                mul_b      = d1_reg[OW:0];
                tb_next    = prod_w;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                mul_a      = d1_reg[OW:0];
                mul_b      = d2_reg[OW:0];
                n1_next    = sum_w;
                d1_next    = prod_w;
                a_next     = sum_w;
                b_next     = prod_w;
                phase_next = PH_RESULT;
                state_next = S_GCD;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    oerr_next = err_reg;
                    rnum_next = err_reg ? '0 : n_ext[rasr_pkg::RESULT_NUM_WIDTH-1:0];
                    rden_next = err_reg ? '0 : d_ext[rasr_pkg::RESULT_DEN_WIDTH-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    phase_next = PH_SECOND;
                    a_next     = n2_reg;
                    b_next     = d2_reg;
                    state_next = S_GCD;
                end
                PH_SECOND:
                begin
                    state_next = S_MUL_A;
                end
                default:
                begin
                    state_next = S_OUT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
            oerr_reg      <= 1'b0;
            sub_reg       <= rasr_pkg::OPC_ADD;
            n1_reg        <= '0;
            d1_reg        <= '0;
            n2_reg        <= '0;
            d2_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            ta_reg        <= '0;
            tb_reg        <= '0;
            rnum_reg      <= '0;
            rden_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
            oerr_reg      <= oerr_next;
            sub_reg       <= sub_next;
            n1_reg        <= n1_next;
            d1_reg        <= d1_next;
            n2_reg        <= n2_next;
            d2_reg        <= d2_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            ta_reg        <= ta_next;
            tb_reg        <= tb_next;
            rnum_reg      <= rnum_next;
            rden_reg      <= rden_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign result_num = rnum_reg;
    assign result_den = rden_reg;
    assign error      = oerr_reg;

    `RASR_ASSERT_SAME(a_div_start_idle, clk, rst_n, div_start, !div_stat.busy)
    `RASR_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && error,
        result_num == '0 && result_den == '0)
    `RASR_ASSERT_SAME(a_den_nonzero, clk, rst_n, out_valid && !error, result_den != '0)
    `RASR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ----- rtl/core/rasr_div.sv -----
`timescale 1ns / 1ps

module rasr_div #(
    parameter int WORK_WIDTH = 33
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [WORK_WIDTH-1:0] dividend,
    input  logic signed [WORK_WIDTH-1:0] divisor,
    output logic signed [WORK_WIDTH-1:0] quotient,
    output logic signed [WORK_WIDTH-1:0] remainder,
    output rasr_pkg::div_stat_t          stat
);

    localparam int CNT_W = $clog2(WORK_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  qneg_reg;
    logic                  rneg_reg;
    logic [WORK_WIDTH-1:0] quot_reg;
    logic [WORK_WIDTH:0]   rem_reg;
    logic [WORK_WIDTH-1:0] dsor_reg;

    logic [WORK_WIDTH:0]   shifted;
    logic [WORK_WIDTH:0]   trial;
    logic [WORK_WIDTH-1:0] mag_x;
    logic [WORK_WIDTH-1:0] mag_y;

    // Magnitudes as unsigned words; the most negative value maps onto itself correctly.
    assign mag_x = dividend[WORK_WIDTH-1] ? WORK_WIDTH'(-dividend) : dividend;
    assign mag_y = divisor[WORK_WIDTH-1] ? WORK_WIDTH'(-divisor) : divisor;

    assign shifted = {rem_reg[WORK_WIDTH-1:0], quot_reg[WORK_WIDTH-1]};
    assign trial   = shifted - {1'b0, dsor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORK_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qneg_reg <= dividend[WORK_WIDTH-1] ^ divisor[WORK_WIDTH-1];
            rneg_reg <= dividend[WORK_WIDTH-1];
            quot_reg <= mag_x;
            rem_reg  <= '0;
            dsor_reg <= mag_y;
        end
        else if (busy_reg)
        begin
            if (!trial[WORK_WIDTH])
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[WORK_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                quot_reg <= {quot_reg[WORK_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Truncating division: the quotient takes the product of signs, the remainder the dividend's.
    assign quotient  = qneg_reg ? WORK_WIDTH'(-quot_reg) : quot_reg;
    assign remainder = rneg_reg ? WORK_WIDTH'(-rem_reg[WORK_WIDTH-1:0])
                                : rem_reg[WORK_WIDTH-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int W = rasr_pkg::DEFAULT_OPERAND_WIDTH;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic signed [rasr_pkg::RESULT_NUM_WIDTH-1:0] num;
        logic signed [rasr_pkg::RESULT_DEN_WIDTH-1:0] den;
        logic                                         err;
    } fraction_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [W-1:0] first_num = '0;
    logic signed [W-1:0] first_den = '0;
    logic signed [W-1:0] second_num = '0;
    logic signed [W-1:0] second_den = '0;
    logic opcode = rasr_pkg::OPC_ADD;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [rasr_pkg::RESULT_NUM_WIDTH-1:0] result_num;
    logic signed [rasr_pkg::RESULT_DEN_WIDTH-1:0] result_den;
    logic error;

    fraction_t pending_results[$];
    int  failures = 0;
    int  cycle_count = 0;
    int  hold_off_cycles = 0;
    bit  sender_done = 1'b0;

    rational_add_sub_reduce uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_num(first_num), .first_den(first_den),
        .second_num(second_num), .second_den(second_den), .opcode(opcode),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_num(result_num), .result_den(result_den), .error(error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Truncating division that tolerates a divisor of zero or minus one.
    function automatic longint trunc_div(longint x, longint y);
        if (y == 0)
            return x;
        if (y == -1)
            return -x;
        return x / y;
    endfunction

    function automatic longint trunc_rem(longint x, longint y);
        if (y == 0 || y == -1)
            return 0;
        return x % y;
    endfunction

    // Euclid without sign normalisation, so the divisor may come out negative.
    function automatic void reduce_pair(inout longint n, inout longint d);
        longint a, b, t;
        a = n;
        b = d;
        while (b != 0)
        begin
            t = b;
            b = trunc_rem(a, b);
            a = t;
        end
        if (a != 0)
        begin
            n = trunc_div(n, a);
            d = trunc_div(d, a);
        end
    endfunction

    function automatic fraction_t predict_sum(logic signed [W-1:0] n1s, logic signed [W-1:0] d1s,
                                              logic signed [W-1:0] n2s, logic signed [W-1:0] d2s,
                                              logic op);
        fraction_t r;
        longint n1, d1, n2, d2, rn, rd;
        n1 = n1s;
        d1 = d1s;
        n2 = n2s;
        d2 = d2s;
        r.num = '0;
        r.den = '0;
        r.err = 1'b1;
        if (d1 == 0 || d2 == 0)
            return r;
        reduce_pair(n1, d1);
        reduce_pair(n2, d2);
        rn = (op == rasr_pkg::OPC_SUB) ? n1 * d2 - n2 * d1 : n1 * d2 + n2 * d1;
        rd = d1 * d2;
        reduce_pair(rn, rd);
        r.num = rn[rasr_pkg::RESULT_NUM_WIDTH-1:0];
        r.den = rd[rasr_pkg::RESULT_DEN_WIDTH-1:0];
        r.err = 1'b0;
        return r;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_fraction(logic signed [W-1:0] n1, logic signed [W-1:0] d1,
                                 logic signed [W-1:0] n2, logic signed [W-1:0] d2,
                                 logic op, bit with_gaps);
        int gap;
        gap = with_gaps ? random_gap() : 0;
        // Valid always falls after the previous transaction before it rises again.
        repeat (gap + 1) @(posedge clk);
        first_num  <= n1;
        first_den  <= d1;
        second_num <= n2;
        second_den <= d2;
        opcode     <= op;
        in_valid   <= 1'b1;
        pending_results.push_back(predict_sum(n1, d1, n2, d2, op));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic signed [W-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return W'($urandom_range(0, 8) - 4);
            1: return W'($urandom_range(0, 200) - 100);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return W'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        logic signed [W-1:0] edge_vals[8];
        edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001,
                      16'shffff, 16'sh0002, 16'sh7ffe, 16'sh8001};
        send_fraction(16'sd1, 16'sd2, 16'sd1, 16'sd3, rasr_pkg::OPC_ADD, 1'b0);
        send_fraction(16'sd1, 16'sd2, 16'sd1, 16'sd3, rasr_pkg::OPC_SUB, 1'b0);
        send_fraction(16'sd5, 16'sd0, 16'sd1, 16'sd3, rasr_pkg::OPC_ADD, 1'b0);
        send_fraction(16'sd5, 16'sd7, 16'sd1, 16'sd0, rasr_pkg::OPC_SUB, 1'b0);
        send_fraction(16'sd0, 16'sd0, 16'sd0, 16'sd0, rasr_pkg::OPC_ADD, 1'b0);
        send_fraction(16'sd0, 16'sd5, 16'sd3, 16'sd9, rasr_pkg::OPC_ADD, 1'b0);
        send_fraction(16'sd0, -16'sd5, 16'sd0, 16'sd7, rasr_pkg::OPC_SUB, 1'b0);
        send_fraction(-16'sd3, -16'sd6, 16'sd4, -16'sd8, rasr_pkg::OPC_ADD, 1'b0);
        send_fraction(16'sd1, -16'sd1, -16'sd1, 16'sd1, rasr_pkg::OPC_SUB, 1'b0);
        for (int i = 0; i < 8; i++)
            send_fraction(edge_vals[i], edge_vals[(i + 3) % 8] | 16'sh0001,
                          edge_vals[(i + 5) % 8], edge_vals[i] | 16'sh0010,
                          logic'(i % 2), 1'b0);
        send_fraction(16'sh8000, 16'sh8000, 16'sh8000, 16'shffff, rasr_pkg::OPC_SUB, 1'b0);
        send_fraction(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, rasr_pkg::OPC_ADD, 1'b0);
        send_fraction(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, rasr_pkg::OPC_SUB, 1'b0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_fraction(random_value(), random_value(), random_value(), random_value(),
                          logic'($urandom_range(0, 1)), 1'b1);
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_off_cycles = 2000;
        for (int i = 0; i < 12; i++)
            send_fraction(random_value(), random_value(), random_value(), random_value(),
                          logic'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic wait_until_drained();
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        wait_until_drained();
        test_random(1200);
        sender_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 30) == 0);
        end
    end

    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_num !== want.num)
                begin
                    $error("result_num expected %0d got %0d", want.num, result_num);
                    failures++;
                end
                if (result_den !== want.den)
                begin
                    $error("result_den expected %0d got %0d", want.den, result_den);
                    failures++;
                end
                if (error !== want.err)
                begin
                    $error("error expected %0b got %0b", want.err, error);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        wait (sender_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rasr_pkg.sv
rtl/core/rasr_div.sv
rtl/core/rational_add_sub_reduce.sv
verif/testbench.sv
